FILE: rtl/core/float_to_decimal_text_defines.svh
// Assertion macros shared by the float-to-text block.
`ifndef FLOAT_TO_DECIMAL_TEXT_DEFINES_SVH
`define FLOAT_TO_DECIMAL_TEXT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FDT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fdt check failed");

// Next-cycle implication, checked outside reset.
`define FDT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fdt check failed");

`endif

FILE: rtl/core/fdt_pkg.sv
// Shared constants, codes and types of the float-to-text block.
`default_nettype none

package fdt_pkg;

	localparam int TEXT_LEN_DEF    = 15;
	localparam int FRAC_DIGITS_DEF = 7;
	localparam int MAX_OUT         = 14;

	localparam int EXP_BIAS  = 127;
	localparam int MANT_BITS = 23;
	localparam int EXP_LIMIT = 31;
	localparam int MANT_W    = MANT_BITS + 1;
	localparam int FRAC_W    = 24;

	// biased exponent thresholds
	localparam int E_TOO_LARGE = EXP_BIAS + EXP_LIMIT;
	localparam int E_TOO_SMALL = EXP_BIAS - MANT_BITS;
	localparam int E_NO_FRAC   = EXP_BIAS + MANT_BITS;
	localparam int SH_BASE     = EXP_BIAS + MANT_BITS - 1;
	localparam int SH_W        = 6;

	localparam int INT_BITS   = EXP_LIMIT;
	localparam int INT_DIGITS = 10;
	localparam int BCD_W      = 4 * INT_DIGITS;
	localparam int CONV_CNT_W = $clog2(EXP_LIMIT + 1);
	localparam int CNT_W      = $clog2(MAX_OUT + 1);
	localparam int FD_IDX_W   = $clog2(MAX_OUT);

	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_DOT   = 8'h2E;
	localparam logic [7:0] CHR_MINUS = 8'h2D;
	localparam logic [7:0] CHR_NUL   = 8'h00;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_LARGE = 2'd1;
	localparam logic [1:0] STATUS_SMALL = 2'd2;

	// shared step unit operations
	localparam logic OP_DABBLE  = 1'b0;
	localparam logic OP_TIMES10 = 1'b1;

	typedef struct packed {
		logic       valid;
		logic [7:0] chr;
		logic       last;
		logic [1:0] status;
	} emit_t;

endpackage

`default_nettype wire

FILE: rtl/core/float_to_decimal_text.sv
// Float-to-decimal-text converter: top level with the output register.
//
// One item on the float channel (float_valid/float_stall, float_bits) is one
// IEEE-754 single-precision pattern. The text channel (text_valid/text_stall)
// returns its decimal text one ASCII character per item, with last set on the
// final character. Zero gives "0.0". Too large (exponent 31 and up, inf, NaN)
// or too small (exponent below -23, denormals) gives one item with character
// 0, last set and status 1 or 2.
// The block converts one float at a time: float_stall is high from the cycle
// after acceptance until the last character has entered the output register.
// Steps per item: decode, then each integer bit (exponent+1, up to 31)
// through the shared double-dabble/times-ten unit, sizing the text, each
// fraction digit slot (up to FRAC_DIGITS, run even for a zero fraction),
// each character emitted (up to 14) and the return to idle. An error item
// goes from decode straight to its single item. A stalled receiver freezes
// the output register and holds the sequencer at its current character; no
// character is lost. Reset clears the sequencer and the output valid.
`default_nettype none
`include "float_to_decimal_text_defines.svh"

module float_to_decimal_text #(
	parameter int TEXT_LEN    = fdt_pkg::TEXT_LEN_DEF,
	parameter int FRAC_DIGITS = fdt_pkg::FRAC_DIGITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        float_valid,
	output logic             float_stall,
	input  wire logic [31:0] float_bits,
	output logic             text_valid,
	input  wire logic        text_stall,
	output logic      [7:0]  character,
	output logic             last,
	output logic      [1:0]  status
);

	fdt_pkg::emit_t emit;
	logic           load;
	logic           text_valid_q;
	logic [7:0]     character_q;
	logic           last_q;
	logic [1:0]     status_q;

	assign load = !text_valid_q || !text_stall;

	fdt_ctrl #(
		.TEXT_LEN    (TEXT_LEN),
		.FRAC_DIGITS (FRAC_DIGITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.float_valid (float_valid),
		.float_bits  (float_bits),
		.float_stall (float_stall),
		.take        (load),
		.emit        (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid_q <= 1'b0;
		end else if (load) begin
			text_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && emit.valid) begin
			character_q <= emit.chr;
			last_q      <= emit.last;
			status_q    <= emit.status;
		end
	end

	assign text_valid = text_valid_q;
	assign character  = character_q;
	assign last       = last_q;
	assign status     = status_q;

	// an idle sequencer has nothing to emit
	`FDT_ASSERT_NOW(a_idle_no_emit, !float_stall, !emit.valid)
	// accepting a float makes the block busy
	`FDT_ASSERT_NEXT(a_accept_busy, float_valid && !float_stall, float_stall)
	// error results are single items
	`FDT_ASSERT_NOW(a_err_last, text_valid && status != fdt_pkg::STATUS_OK, last)
	// text characters are never NUL
	`FDT_ASSERT_NOW(a_ok_printable, text_valid && status == fdt_pkg::STATUS_OK,
		character != fdt_pkg::CHR_NUL)

endmodule

`default_nettype wire

FILE: rtl/core/fdt_step.sv
// Shared decimal step unit: one double-dabble shift or one multiply-by-ten.
`default_nettype none

module fdt_step (
	input  wire logic                     op,
	input  wire logic [fdt_pkg::BCD_W-1:0] opnd,
	input  wire logic                     bit_in,
	output logic      [fdt_pkg::BCD_W-1:0] res,
	output logic      [3:0]                digit
);

	localparam int BW = fdt_pkg::BCD_W;
	localparam int FW = fdt_pkg::FRAC_W;

	logic [BW-1:0]   adj;
	logic [FW+3:0]   prod;

	always_comb begin
		for (int k = 0; k < fdt_pkg::INT_DIGITS; k++) begin
			if (opnd[4*k +: 4] >= 4'd5)
				adj[4*k +: 4] = opnd[4*k +: 4] + 4'd3;
			else
				adj[4*k +: 4] = opnd[4*k +: 4];
		end
	end

	// f*10 = f*8 + f*2; the top nibble is the next decimal digit
	assign prod = {1'b0, opnd[FW-1:0], 3'b000} + {3'b000, opnd[FW-1:0], 1'b0};

	always_comb begin
		unique case (op)
			fdt_pkg::OP_DABBLE: begin
				res   = {adj[BW-2:0], bit_in};
				digit = 4'd0;
			end
			fdt_pkg::OP_TIMES10: begin
				res   = {{(BW-FW){1'b0}}, prod[FW-1:0]};
				digit = prod[FW+3:FW];
			end
			default: begin
				res   = opnd;
				digit = 4'd0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/fdt_ctrl.sv
// Sequencer: decodes the float, converts its parts with the step unit, emits text.
`default_nettype none

module fdt_ctrl #(
	parameter int TEXT_LEN    = fdt_pkg::TEXT_LEN_DEF,
	parameter int FRAC_DIGITS = fdt_pkg::FRAC_DIGITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          float_valid,
	input  wire logic [31:0]   float_bits,
	output logic               float_stall,
	input  wire logic          take,
	output fdt_pkg::emit_t     emit
);

	localparam int CW  = fdt_pkg::CNT_W;
	localparam int BW  = fdt_pkg::BCD_W;
	localparam int FW  = fdt_pkg::FRAC_W;
	localparam int IB  = fdt_pkg::INT_BITS;
	localparam int MW  = fdt_pkg::MANT_W;
	localparam int MB  = fdt_pkg::MANT_BITS;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_CONV   = 3'd2;
	localparam logic [2:0] S_COUNT  = 3'd3;
	localparam logic [2:0] S_FRAC   = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;
	localparam logic [2:0] S_ERR    = 3'd6;

	logic [2:0]                        state_q;
	logic [31:0]                       bits_q;
	logic                              neg_q;
	logic [1:0]                        err_q;
	logic [fdt_pkg::CONV_CNT_W-1:0]    cnt_q;
	logic [IB-1:0]                     mbits_q;
	logic [BW-1:0]                     bcd_q;
	logic [FW-1:0]                     frac_q;
	logic [CW-1:0]                     nd_q;
	logic [CW-1:0]                     maxd_q;
	logic [CW-1:0]                     fidx_q;
	logic [CW-1:0]                     keep_q;
	logic [CW-1:0]                     n_q;
	logic [CW-1:0]                     e_q;
	logic [3:0]                        fd_q [fdt_pkg::MAX_OUT];

	// decode of the captured bits
	logic [7:0]            e8;
	logic                  is_zero;
	logic [MW-1:0]         mant;
	logic [fdt_pkg::SH_W-1:0] sh;
	logic [MW+MB-1:0]      wide;

	assign e8      = bits_q[30:23];
	assign is_zero = (bits_q[30:0] == 31'd0);
	assign mant    = {1'b1, bits_q[MB-1:0]};
	assign sh      = fdt_pkg::SH_W'(8'(fdt_pkg::SH_BASE) - e8);
	assign wide    = {mant, {MB{1'b0}}} >> sh;

	// shared step unit
	logic          op;
	logic [BW-1:0] opnd;
	logic [BW-1:0] step_res;
	logic [3:0]    step_digit;

	assign op   = (state_q == S_FRAC) ? fdt_pkg::OP_TIMES10 : fdt_pkg::OP_DABBLE;
	assign opnd = (state_q == S_FRAC) ? {{(BW-FW){1'b0}}, frac_q} : bcd_q;

	fdt_step u_step (
		.op     (op),
		.opnd   (opnd),
		.bit_in (mbits_q[IB-1]),
		.res    (step_res),
		.digit  (step_digit)
	);

	// integer digit count and fraction digit budget
	logic [CW-1:0] nd_c;
	logic [CW-1:0] maxd_c;

	always_comb begin
		nd_c = CW'(1);
		for (int k = 0; k < fdt_pkg::INT_DIGITS; k++) begin
			if (bcd_q[4*k +: 4] != 4'd0)
				nd_c = CW'(k + 1);
		end
	end

	always_comb begin
		int npre;
		int t;
		npre = int'(neg_q) + int'(nd_c) + 1;
		t = TEXT_LEN - 1 - npre;
		if (t > FRAC_DIGITS)
			t = FRAC_DIGITS;
		if (t > fdt_pkg::MAX_OUT - npre)
			t = fdt_pkg::MAX_OUT - npre;
		if (t < 1)
			t = 1;
		maxd_c = t[CW-1:0];
	end

	logic [CW-1:0] keep_nx;
	assign keep_nx = (step_digit != 4'd0) ? fidx_q + 1'b1 : keep_q;

	// character at the current emit position
	logic [CW-1:0] ipos;
	logic [CW-1:0] ksel;
	logic [CW-1:0] fsel;
	logic [7:0]    chr_c;
	logic          last_c;

	assign ipos   = e_q - CW'(neg_q);
	assign ksel   = nd_q - ipos - 1'b1;
	assign fsel   = ipos - nd_q - 1'b1;
	assign last_c = (e_q == n_q - 1'b1);

	always_comb begin
		priority if (neg_q && e_q == '0)
			chr_c = fdt_pkg::CHR_MINUS;
		else if (ipos < nd_q)
			chr_c = fdt_pkg::CHR_ZERO + {4'd0, bcd_q[{ksel, 2'b00} +: 4]};
		else if (ipos == nd_q)
			chr_c = fdt_pkg::CHR_DOT;
		else
			chr_c = fdt_pkg::CHR_ZERO + {4'd0, fd_q[fsel[fdt_pkg::FD_IDX_W-1:0]]};
	end

	always_comb begin
		emit = '0;
		if (state_q == S_EMIT) begin
			emit.valid  = 1'b1;
			emit.chr    = chr_c;
			emit.last   = last_c;
			emit.status = fdt_pkg::STATUS_OK;
		end else if (state_q == S_ERR) begin
			emit.valid  = 1'b1;
			emit.chr    = fdt_pkg::CHR_NUL;
			emit.last   = 1'b1;
			emit.status = err_q;
		end
	end

	assign float_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (float_valid)
						state_q <= S_DECODE;
				end
				S_DECODE: begin
					if (is_zero)
						state_q <= S_COUNT;
					else if (e8 >= 8'(fdt_pkg::E_TOO_LARGE) || e8 < 8'(fdt_pkg::E_TOO_SMALL))
						state_q <= S_ERR;
					else if (e8 >= 8'(fdt_pkg::EXP_BIAS))
						state_q <= S_CONV;
					else
						state_q <= S_COUNT;
				end
				S_CONV: begin
					if (cnt_q == fdt_pkg::CONV_CNT_W'(1))
						state_q <= S_COUNT;
				end
				S_COUNT: state_q <= S_FRAC;
				S_FRAC: begin
					if (fidx_q == maxd_q - 1'b1)
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (take && last_c)
						state_q <= S_IDLE;
				end
				S_ERR: begin
					if (take)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (float_valid)
					bits_q <= float_bits;
			end
			S_DECODE: begin
				neg_q   <= bits_q[31] && !is_zero;
				err_q   <= (e8 >= 8'(fdt_pkg::E_TOO_LARGE)) ? fdt_pkg::STATUS_LARGE
				                                              : fdt_pkg::STATUS_SMALL;
				bcd_q   <= '0;
				mbits_q <= {mant, {(IB-MW){1'b0}}};
				cnt_q   <= fdt_pkg::CONV_CNT_W'(e8 - 8'(fdt_pkg::EXP_BIAS - 1));
				if (is_zero || e8 >= 8'(fdt_pkg::E_NO_FRAC))
					frac_q <= '0;
				else
					frac_q <= wide[FW-1:0];
			end
			S_CONV: begin
				bcd_q   <= step_res;
				mbits_q <= {mbits_q[IB-2:0], 1'b0};
				cnt_q   <= cnt_q - 1'b1;
			end
			S_COUNT: begin
				nd_q   <= nd_c;
				maxd_q <= maxd_c;
				fidx_q <= '0;
				keep_q <= '0;
			end
			S_FRAC: begin
				fd_q[fidx_q[fdt_pkg::FD_IDX_W-1:0]] <= step_digit;
				frac_q <= step_res[FW-1:0];
				fidx_q <= fidx_q + 1'b1;
				keep_q <= keep_nx;
				e_q    <= '0;
				// prefix plus kept fraction digits, at least one
				n_q    <= CW'(neg_q) + nd_q + 1'b1
				          + ((keep_nx == '0) ? CW'(1) : keep_nx);
			end
			S_EMIT: begin
				if (take)
					e_q <= e_q + 1'b1;
			end
			S_ERR: ;
			default: ;
		endcase
	end

endmodule

`default_nettype wire
